[rtl/core/pbwt_pkg.sv]
package pbwt_pkg;

   // widest length-delimited payload length, in bits
   localparam int LENGTH_BITS = 32;

   localparam logic [7:0] GROUP_MASK  = 8'h7F;
   localparam logic [7:0] MORE_BIT    = 8'h80;
   localparam int         SHIFT_LIMIT = 70;
   localparam logic [7:0] TYPE_MASK   = 8'h07;
   localparam int         MAX_GROUPS  = SHIFT_LIMIT / 7;

   // parser phases
   localparam logic [2:0] PH_TAG     = 3'd0;
   localparam logic [2:0] PH_VARINT  = 3'd1;
   localparam logic [2:0] PH_FIXED   = 3'd2;
   localparam logic [2:0] PH_LENGTH  = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_DROP    = 3'd5;

   // result kinds
   localparam logic [1:0] K_SCALAR  = 2'd0;
   localparam logic [1:0] K_HEADER  = 2'd1;
   localparam logic [1:0] K_PAYLOAD = 2'd2;
   localparam logic [1:0] K_ERROR   = 2'd3;

   // wire types
   localparam logic [2:0] WT_VARINT  = 3'd0;
   localparam logic [2:0] WT_FIXED64 = 3'd1;
   localparam logic [2:0] WT_LENGTH  = 3'd2;
   localparam logic [2:0] WT_FIXED32 = 3'd5;

   // error codes
   localparam logic [2:0] E_NONE   = 3'd0;
   localparam logic [2:0] E_WIRE   = 3'd1;
   localparam logic [2:0] E_FIELD0 = 3'd2;
   localparam logic [2:0] E_LONG   = 3'd3;
   localparam logic [2:0] E_TRUNC  = 3'd4;
   localparam logic [2:0] E_LENGTH = 3'd5;

   typedef struct packed {
      logic [63:0] acc;
      logic [3:0]  groups;
      logic        done;
      logic        too_long;
   } varint_type;

   typedef struct packed {
      logic [2:0]  error_code;
      logic [7:0]  payload_byte;
      logic [63:0] value;
      logic [2:0]  wire_type;
      logic [31:0] field_number;
   } result_type;

   // fold one base-128 group into the accumulator; bits past 63 are lost
   function automatic varint_type varint_step(logic [63:0] acc, logic [3:0] groups,
                                              logic [7:0] b);
      varint_type  r;
      logic [6:0]  shift;
      logic [63:0] grp;
      logic [4:0]  next_groups;
      shift       = 7'(groups) * 7'd7;
      grp         = {56'd0, b & GROUP_MASK};
      next_groups = 5'(groups) + 5'd1;
      r.acc       = acc;
      if (shift < 7'd64) begin
         r.acc = acc | (grp << shift[5:0]);
      end
      r.groups   = next_groups[3:0];
      r.done     = (b & MORE_BIT) == 8'd0;
      r.too_long = !r.done && (next_groups >= 5'(MAX_GROUPS));
      return r;
   endfunction

endpackage

[rtl/core/protobuf_wire_tokenizer.sv]
// Protocol buffers wire-format tokenizer. Feed the encoded message one byte per request
// with req_tlast on its final byte; the block takes one byte per clock while rsp_tready
// stays high, each byte updating the parser state as it is taken and any result landing
// in an output register, shown in the cycle after its byte is taken. A scalar field
// gives one result (rsp_tuser = 0) when its value completes, a length-delimited field
// gives a header carrying its length (1) and then one result per payload byte (2), and
// an error (3) drops the remainder of the message up to and including its final byte.
// rsp_tlast echoes req_tlast of the byte that produced the result.
module protobuf_wire_tokenizer
   import pbwt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // last_byte

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] field_number, [34:32] wire_type, [98:35] value, [106:99] payload_byte,
   // [109:107] error_code, [111:110] zero
   output logic [111:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,   // [1:0] kind
   output logic         rsp_tlast    // message_end
);

   logic [2:0]             phase_ff, phase_in;
   logic [63:0]            acc_ff, acc_in;
   logic [3:0]             groups_ff, groups_in;
   logic [31:0]            field_ff, field_in;
   logic [2:0]             wire_ff, wire_in;
   logic [3:0]             fixed_ff, fixed_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_data_ff;
   logic [1:0]             rsp_kind_ff;
   logic                   rsp_end_ff;

   logic                   accept;
   logic                   emit;
   logic [1:0]             kind;
   result_type             res;
   logic [2:0]             err;
   varint_type             vs;
   logic [7:0]             b;
   logic                   last;
   logic [63:0]            fixed_acc;
   logic [3:0]             fixed_next;
   logic [3:0]             fixed_need;
   logic [LENGTH_BITS-1:0] left_next;
   logic [31:0]            tag_field;
   logic [2:0]             tag_wire;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign last       = req_tlast;

   assign vs         = varint_step(acc_ff, groups_ff, b);
   assign tag_field  = vs.acc[34:3];
   assign tag_wire   = vs.acc[2:0] & TYPE_MASK[2:0];
   assign fixed_acc  = acc_ff | ({56'd0, b} << {fixed_ff[2:0], 3'b000});
   assign fixed_next = fixed_ff + 4'd1;
   assign fixed_need = (wire_ff == WT_FIXED64) ? 4'd8 : 4'd4;
   assign left_next  = left_ff - LENGTH_BITS'(left_ff != '0);

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      groups_in = groups_ff;
      field_in  = field_ff;
      wire_in   = wire_ff;
      fixed_in  = fixed_ff;
      left_in   = left_ff;
      emit      = 1'b0;
      kind      = K_SCALAR;
      res       = '0;
      err       = E_NONE;

      case (phase_ff)
         PH_TAG: begin
            if (vs.too_long) begin
               err = E_LONG;
            end else if (!vs.done) begin
               if (last) begin
                  err = E_TRUNC;
               end else begin
                  acc_in    = vs.acc;
                  groups_in = vs.groups;
               end
            end else begin
               field_in  = tag_field;
               wire_in   = tag_wire;
               acc_in    = '0;
               groups_in = '0;
               fixed_in  = '0;
               if (!(tag_wire inside {WT_VARINT, WT_FIXED64, WT_LENGTH, WT_FIXED32})) begin
                  err = E_WIRE;
               end else if (tag_field == 32'd0) begin
                  err = E_FIELD0;
               end else if (last) begin
                  err = E_TRUNC;
               end else if (tag_wire == WT_VARINT) begin
                  phase_in = PH_VARINT;
               end else if (tag_wire == WT_LENGTH) begin
                  phase_in = PH_LENGTH;
               end else begin
                  phase_in = PH_FIXED;
               end
            end
         end
         PH_VARINT: begin
            if (vs.too_long) begin
               err = E_LONG;
            end else if (!vs.done) begin
               if (last) begin
                  err = E_TRUNC;
               end else begin
                  acc_in    = vs.acc;
                  groups_in = vs.groups;
               end
            end else begin
               acc_in           = '0;
               groups_in        = '0;
               fixed_in         = '0;
               phase_in         = PH_TAG;
               emit             = 1'b1;
               kind             = K_SCALAR;
               res.field_number = field_ff;
               res.wire_type    = wire_ff;
               res.value        = vs.acc;
            end
         end
         PH_FIXED: begin
            if (fixed_next >= fixed_need) begin
               acc_in           = '0;
               groups_in        = '0;
               fixed_in         = '0;
               phase_in         = PH_TAG;
               emit             = 1'b1;
               kind             = K_SCALAR;
               res.field_number = field_ff;
               res.wire_type    = wire_ff;
               res.value        = fixed_acc;
            end else if (last) begin
               err = E_TRUNC;
            end else begin
               acc_in   = fixed_acc;
               fixed_in = fixed_next;
            end
         end
         PH_LENGTH: begin
            if (vs.too_long) begin
               err = E_LONG;
            end else if (!vs.done) begin
               if (last) begin
                  err = E_TRUNC;
               end else begin
                  acc_in    = vs.acc;
                  groups_in = vs.groups;
               end
            end else begin
               acc_in    = '0;
               groups_in = '0;
               fixed_in  = '0;
               if (|vs.acc[63:LENGTH_BITS]) begin
                  err = E_LENGTH;
               end else if (vs.acc != 64'd0 && last) begin
                  err = E_TRUNC;
               end else begin
                  left_in          = vs.acc[LENGTH_BITS-1:0];
                  phase_in         = (vs.acc == 64'd0) ? PH_TAG : PH_PAYLOAD;
                  emit             = 1'b1;
                  kind             = K_HEADER;
                  res.field_number = field_ff;
                  res.wire_type    = wire_ff;
                  res.value        = vs.acc;
               end
            end
         end
         PH_PAYLOAD: begin
            left_in = left_next;
            if (left_next == '0) begin
               phase_in = PH_TAG;
            end
            if (left_next != '0 && last) begin
               err = E_TRUNC;
            end else begin
               emit             = 1'b1;
               kind             = K_PAYLOAD;
               res.field_number = field_ff;
               res.wire_type    = wire_ff;
               res.payload_byte = b;
            end
         end
         PH_DROP: begin
            if (last) begin
               acc_in    = '0;
               groups_in = '0;
               fixed_in  = '0;
               left_in   = '0;
               phase_in  = PH_TAG;
            end
         end
         default: begin
            phase_in = PH_TAG;
         end
      endcase

      // any error clears the value state and skips to the end of the message
      if (err != E_NONE) begin
         acc_in         = '0;
         groups_in      = '0;
         fixed_in       = '0;
         left_in        = '0;
         phase_in       = last ? PH_TAG : PH_DROP;
         emit           = 1'b1;
         kind           = K_ERROR;
         res            = '0;
         res.error_code = err;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TAG;
         acc_ff       <= '0;
         groups_ff    <= '0;
         field_ff     <= '0;
         wire_ff      <= '0;
         fixed_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff  <= phase_in;
            acc_ff    <= acc_in;
            groups_ff <= groups_in;
            field_ff  <= field_in;
            wire_ff   <= wire_in;
            fixed_ff  <= fixed_in;
            left_ff   <= left_in;
         end
      end
   end

   // hold the result until it is taken
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= res;
         rsp_kind_ff <= kind;
         rsp_end_ff  <= last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_end_ff;

endmodule

[sim/tb.sv]
module tb
   import pbwt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          RANDOM_BYTES = 650;
   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int          REPORT_MAX   = 10;

   // outcome of folding one base-128 group
   localparam logic [1:0] GRP_MORE = 2'd0;
   localparam logic [1:0] GRP_DONE = 2'd1;
   localparam logic [1:0] GRP_OVER = 2'd2;

   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         hold;    // wait for all outstanding results before this request
   } request_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] fnum;
      logic [2:0]  wt;
      logic [63:0] value;
      logic [7:0]  pb;
      logic [2:0]  err;
      logic        msg_end;
   } token_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;    // [7:0] data_byte
   logic         req_tlast = 1'b0;  // last_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;         // [31:0] field, [34:32] wire, [98:35] value, [106:99] byte,
                                    // [109:107] error, [111:110] zero
   logic [1:0]   rsp_tuser;         // [1:0] kind
   logic         rsp_tlast;         // message_end

   protobuf_wire_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   request_type bytes_queued[$];
   token_type   tokens_due[$];
   logic [7:0]  frame[$];

   // tokenizer state
   logic [2:0]  parse_phase = PH_TAG;
   logic [63:0] fold_acc    = '0;
   int          groups_seen = 0;
   int          fixed_seen  = 0;
   logic [31:0] cur_field   = '0;
   logic [2:0]  cur_wire    = '0;
   logic [63:0] bytes_owed  = '0;

   int          mismatches = 0;
   int          kinds_seen[4];
   int          frames_sent = 0;
   int          clean_bytes = 0;
   int          pauses = 0;
   int unsigned cycles = 0;

   function automatic logic [1:0] absorb_group(input logic [7:0] b);
      int sh;
      sh = 7 * groups_seen;
      if (sh < 64) fold_acc = fold_acc | ({57'd0, b[6:0]} << sh);
      if (!b[7]) return GRP_DONE;
      groups_seen++;
      if (7 * groups_seen >= SHIFT_LIMIT) return GRP_OVER;
      return GRP_MORE;
   endfunction

   task automatic clear_fold();
      fold_acc    = '0;
      groups_seen = 0;
      fixed_seen  = 0;
   endtask

   task automatic emit_token(input logic [1:0] kind, input logic [31:0] fnum,
                             input logic [2:0] wt, input logic [63:0] value,
                             input logic [7:0] pb, input logic [2:0] err, input logic last);
      token_type t;
      t = '{kind: kind, fnum: fnum, wt: wt, value: value, pb: pb, err: err, msg_end: last};
      tokens_due.push_back(t);
   endtask

   task automatic reject(input logic [2:0] code, input logic last);
      clear_fold();
      bytes_owed  = '0;
      parse_phase = last ? PH_TAG : PH_DROP;
      emit_token(K_ERROR, '0, '0, '0, '0, code, last);
   endtask

   task automatic tokenize_byte(input logic [7:0] b, input logic last);
      logic [1:0]  st;
      logic [63:0] v;
      int          need;
      case (parse_phase)
         PH_TAG: begin
            st = absorb_group(b);
            if (st == GRP_OVER) reject(E_LONG, last);
            else if (st == GRP_MORE) begin
               if (last) reject(E_TRUNC, last);
            end else begin
               cur_field = fold_acc[34:3];
               cur_wire  = fold_acc[2:0];
               clear_fold();
               if (cur_wire != WT_VARINT && cur_wire != WT_FIXED64 &&
                   cur_wire != WT_LENGTH && cur_wire != WT_FIXED32) reject(E_WIRE, last);
               else if (cur_field == 0) reject(E_FIELD0, last);
               else if (last) reject(E_TRUNC, last);
               else if (cur_wire == WT_VARINT) parse_phase = PH_VARINT;
               else if (cur_wire == WT_LENGTH) parse_phase = PH_LENGTH;
               else parse_phase = PH_FIXED;
            end
         end
         PH_VARINT, PH_LENGTH: begin
            st = absorb_group(b);
            if (st == GRP_OVER) reject(E_LONG, last);
            else if (st == GRP_MORE) begin
               if (last) reject(E_TRUNC, last);
            end else begin
               v = fold_acc;
               clear_fold();
               if (parse_phase == PH_VARINT) begin
                  parse_phase = PH_TAG;
                  emit_token(K_SCALAR, cur_field, cur_wire, v, '0, E_NONE, last);
               end else if ((v >> LENGTH_BITS) != 0) reject(E_LENGTH, last);
               else if (v != 0 && last) reject(E_TRUNC, last);
               else begin
                  bytes_owed  = v;
                  parse_phase = (v == 0) ? PH_TAG : PH_PAYLOAD;
                  emit_token(K_HEADER, cur_field, cur_wire, v, '0, E_NONE, last);
               end
            end
         end
         PH_FIXED: begin
            need       = (cur_wire == WT_FIXED64) ? 8 : 4;
            fold_acc   = fold_acc | ({56'd0, b} << (8 * (fixed_seen & 7)));
            fixed_seen = fixed_seen + 1;
            if (fixed_seen >= need) begin
               v = fold_acc;
               clear_fold();
               parse_phase = PH_TAG;
               emit_token(K_SCALAR, cur_field, cur_wire, v, '0, E_NONE, last);
            end else if (last) reject(E_TRUNC, last);
         end
         PH_PAYLOAD: begin
            if (bytes_owed > 0) bytes_owed--;
            if (bytes_owed == 0) begin
               parse_phase = PH_TAG;
               emit_token(K_PAYLOAD, cur_field, cur_wire, '0, b, E_NONE, last);
            end else if (last) reject(E_TRUNC, last);
            else emit_token(K_PAYLOAD, cur_field, cur_wire, '0, b, E_NONE, 1'b0);
         end
         default: begin
            // drop everything up to the end of the failed message
            if (last) begin
               clear_fold();
               bytes_owed  = '0;
               parse_phase = PH_TAG;
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------- message building

   task automatic put_varint(input logic [63:0] v, input int groups);
      int   n;
      logic more;
      n = 0;
      do begin
         n++;
         more = ((v >> 7) != 0) || (n < groups);
         frame.push_back({more, v[6:0]});
         v = v >> 7;
      end while (more);
   endtask

   function automatic int pad_groups();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(2, 10) : 1;
   endfunction

   function automatic logic [63:0] pick_field();
      case ($urandom_range(0, 9))
         0:       return 64'hFFFF_FFFF;
         1:       return {$urandom, $urandom} >> 3;   // wider than 32 bits, cut by the block
         2:       return 64'($urandom | 1);
         3, 4:    return 64'($urandom_range(16, 2047));
         default: return 64'($urandom_range(1, 15));
      endcase
   endfunction

   task automatic add_tail();
      repeat ($urandom_range(0, 4)) frame.push_back(8'($urandom));
   endtask

   task automatic add_field();
      logic [2:0]  wt;
      logic [63:0] v;
      int          n;
      int          fill;
      case ($urandom_range(0, 3))
         0:       wt = WT_VARINT;
         1:       wt = WT_FIXED64;
         2:       wt = WT_LENGTH;
         default: wt = WT_FIXED32;
      endcase
      put_varint((pick_field() << 3) | 64'(wt), pad_groups());
      if (wt == WT_VARINT) begin
         case ($urandom_range(0, 9))
            0: put_varint('0, pad_groups());
            1: put_varint('1, 10);
            2: begin
               // ten groups whose top bits fall past bit 63
               repeat (9) frame.push_back(8'h80 | 8'($urandom));
               frame.push_back(8'($urandom_range(0, 127)));
            end
            default: put_varint({$urandom, $urandom} >> $urandom_range(0, 63), pad_groups());
         endcase
      end else if (wt == WT_LENGTH) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
         put_varint(64'(n), pad_groups());
         repeat (n) frame.push_back(8'($urandom));
      end else begin
         n    = (wt == WT_FIXED64) ? 8 : 4;
         fill = $urandom_range(0, 5);
         repeat (n) frame.push_back(fill == 0 ? 8'hFF : fill == 1 ? 8'h00 : 8'($urandom));
      end
   endtask

   task automatic ship_frame(input bit hold);
      request_type r;
      foreach (frame[i]) begin
         r = '{data: frame[i], last: (i == frame.size() - 1), hold: hold && (i == 0)};
         bytes_queued.push_back(r);
      end
      frame.delete();
      frames_sent++;
      if (hold) pauses++;
   endtask

   // ---------------------------------------------------------------- request driver

   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_requests
      request_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         burst_left = $urandom_range(1, 48);
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            head = bytes_queued.pop_front();
            tokenize_byte(head.data, head.last);
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else if (gap_left > 0) gap_left--;
         if (bytes_queued.size() == 0 || gap_left > 0 ||
             (bytes_queued[0].hold && tokens_due.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= bytes_queued[0].data;
            req_tlast  <= bytes_queued[0].last;
         end
      end
   end

   // ---------------------------------------------------------------- result monitor

   int stall_left = 0;
   int run_left   = 0;

   always @(posedge clock) begin : watch_results
      token_type want;
      token_type got;
      logic      ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{kind: rsp_tuser, fnum: rsp_tdata[31:0], wt: rsp_tdata[34:32],
                    value: rsp_tdata[98:35], pb: rsp_tdata[106:99],
                    err: rsp_tdata[109:107], msg_end: rsp_tlast};
            kinds_seen[rsp_tuser]++;
            if (tokens_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected result: kind %0d field %0d value %h err %0d",
                           got.kind, got.fnum, got.value, got.err);
            end else begin
               want = tokens_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("mismatch (exp/got): kind %0d/%0d field %0d/%0d wire %0d/%0d",
                              want.kind, got.kind, want.fnum, got.fnum, want.wt, got.wt,
                              " value %h/%h byte %h/%h err %0d/%0d end %0d/%0d",
                              want.value, got.value, want.pb, got.pb, want.err, got.err,
                              want.msg_end, got.msg_end);
               end
            end
         end
         // receiver pattern: steady runs, short hiccups, long stalls, flicker
         if (stall_left > 0) begin
            stall_left--;
            ready = 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            ready = 1'b1;
         end else begin
            case ($urandom_range(0, 3))
               0: run_left = $urandom_range(20, 80);
               1: begin
                  stall_left = $urandom_range(1, 3);
                  run_left   = $urandom_range(0, 4);
               end
               2: begin
                  stall_left = $urandom_range(5, 20);
                  run_left   = $urandom_range(1, 10);
               end
               default: begin
                  stall_left = $urandom_range(0, 1);
                  run_left   = $urandom_range(0, 2);
               end
            endcase
            ready = (stall_left == 0);
         end
         rsp_tready <= ready;
      end
   end

   always @(posedge clock) begin : watchdog
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d requests and %0d results outstanding",
                  cycles, bytes_queued.size(), tokens_due.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      int          pick;
      logic [63:0] fnum;

      // varint 150, fixed32 all ones, empty payload, one-byte payload ending the message
      frame = '{8'h08, 8'h96, 8'h01, 8'h15, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'h2A, 8'h00, 8'h22, 8'h01, 8'hAB};
      ship_frame(1'b0);
      frame = '{8'h0B};                    // wire type 3
      ship_frame(1'b0);
      frame = '{8'h00};                    // field zero
      ship_frame(1'b0);
      frame = '{8'h08};                    // tag with no value
      ship_frame(1'b0);
      frame = '{8'h0A, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10};   // length 2^32 on the final byte
      ship_frame(1'b0);
      frame = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      ship_frame(1'b0);                    // over-long tag ending the message

      while (bytes_queued.size() < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         fnum = 64'($urandom_range(1, 300));
         if (pick < 78) begin
            repeat ($urandom_range(1, 5)) add_field();
            clean_bytes += frame.size();
         end else if (pick < 86) begin
            // cut short somewhere inside
            repeat ($urandom_range(1, 3)) add_field();
            frame = frame[0:$urandom_range(0, frame.size() - 2)];
         end else if (pick < 89) begin
            repeat ($urandom_range(0, 2)) add_field();
            put_varint((fnum << 3) | ($urandom_range(0, 1) ? 64'($urandom_range(3, 4))
                                                           : 64'($urandom_range(6, 7))),
                       pad_groups());
            add_tail();
         end else if (pick < 92) begin
            repeat ($urandom_range(0, 2)) add_field();
            put_varint((64'($urandom_range(0, 3)) << 35) | 64'(WT_VARINT), pad_groups());
            add_tail();
         end else if (pick < 95) begin
            repeat ($urandom_range(0, 2)) add_field();
            case ($urandom_range(0, 2))
               0:       ;
               1:       put_varint((fnum << 3) | 64'(WT_VARINT), 1);
               default: put_varint((fnum << 3) | 64'(WT_LENGTH), 1);
            endcase
            repeat ($urandom_range(10, 12)) frame.push_back(8'h80 | 8'($urandom));
            add_tail();
         end else if (pick < 97) begin
            repeat ($urandom_range(0, 2)) add_field();
            put_varint((fnum << 3) | 64'(WT_LENGTH), 1);
            put_varint({$urandom, $urandom} | (64'd1 << $urandom_range(32, 63)), 1);
            add_tail();
         end else begin
            repeat ($urandom_range(1, 10)) frame.push_back(8'($urandom));
         end
         ship_frame(frames_sent % 8 == 1);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (bytes_queued.size() != 0 || req_tvalid) @(posedge clock);
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (tokens_due.size() != 0)
         $display("%0d results never arrived", tokens_due.size());
      $display("sent %0d messages, %0d in well-formed fields, with %0d drain pauses",
               frames_sent, clean_bytes, pauses);
      $display("checked %0d scalars, %0d headers, %0d payload bytes, %0d errors; %0d bad",
               kinds_seen[K_SCALAR], kinds_seen[K_HEADER], kinds_seen[K_PAYLOAD],
               kinds_seen[K_ERROR], mismatches);
      if (mismatches == 0 && tokens_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
